// File: sv/lz_range_coder_decompressor_defines.svh
// Assertion macros shared by the decompressor RTL.
`ifndef LZ_RANGE_CODER_DECOMPRESSOR_DEFINES_SVH
`define LZ_RANGE_CODER_DECOMPRESSOR_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define LZRC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define LZRC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/lzrc_pkg.sv
// Shared constants for the range-coded LZ decompressor.
`timescale 1ns / 1ps
`default_nettype none
package lzrc_pkg;
   localparam int unsigned WordW = 32;

   // Decoder phase codes
   localparam logic [3:0] PH_IDLE  = 4'd4;
   localparam logic [3:0] PH_FLAG  = 4'd5;
   localparam logic [3:0] PH_LIT   = 4'd6;
   localparam logic [3:0] PH_MLEN  = 4'd7;
   localparam logic [3:0] PH_OFFLO = 4'd8;
   localparam logic [3:0] PH_OFFHI = 4'd9;
   localparam logic [3:0] PH_END   = 4'd10;
   localparam logic [3:0] PH_BAD   = 4'd11;

   // Status codes
   localparam logic [1:0] ST_RUN  = 2'd0;
   localparam logic [1:0] ST_END  = 2'd1;
   localparam logic [1:0] ST_BAD  = 2'd2;
endpackage
`default_nettype wire

// File: sv/lz_range_coder_decompressor.sv
// Top level of the range-coded LZ77 stream decompressor.
`timescale 1ns / 1ps
`default_nettype none
`include "lz_range_coder_decompressor_defines.svh"
// Each transfer in offers at most one compressed byte; the decoder runs until it emits one
// byte, needs a second byte, or halts, and answers with exactly one transfer out. After reset
// a clearing pass initialises the frequency, total and window memories and no item is taken
// meanwhile. An item that completes a symbol adds two divisions on the shared divider, a
// cumulative walk over the frequency entries of its context (up to 256), the multiplies for
// low and range and, when a context total wraps, a rescale over that context, all through the
// single frequency memory port. One item is in work at a time; a finished result waits in the
// output register while the next item is taken.
module lz_range_coder_decompressor (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // in_byte
   input  wire logic       req_tuser,   // in_valid
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // out_byte
   output logic [3:0]      rsp_tuser    // byte_taken, out_valid, status[1:0]
);
   import lzrc_pkg::*;

   typedef enum logic [16:0] {
      S_CLEAR = 17'h00001, S_IDLE  = 17'h00002, S_STEP  = 17'h00004,
      S_WINWR = 17'h00008, S_CTX   = 17'h00010, S_TOTRD = 17'h00020,
      S_DIVR  = 17'h00040, S_DIVRW = 17'h00080, S_DIVIW = 17'h00100,
      S_WALKA = 17'h00200, S_WALKB = 17'h00400, S_MUL1  = 17'h00800,
      S_MUL2  = 17'h01000, S_RSA   = 17'h02000, S_RSB   = 17'h04000,
      S_SYM   = 17'h08000, S_DONE  = 17'h10000
   } state_type;

   state_type   state_ff, state_in;
   logic [3:0]  phase_ff, phase_in;
   logic [31:0] low_ff, low_in, code_ff, code_in, range_ff, range_in, idx_ff, idx_in;
   logic [15:0] copy_ff, copy_in, wp_ff, wp_in, tot_ff, tot_in, f_ff, f_in, clr_ff, clr_in;
   logic [8:0]  run_ff, run_in;
   logic        fill_ff, fill_in, avail_ff, avail_in, taken_ff, taken_in, emit_ff, emit_in;
   logic [7:0]  mask_ff, mask_in, flag_ff, flag_in, mlen_ff, mlen_in, offlo_ff, offlo_in;
   logic [7:0]  byte_ff, byte_in, ob_ff, ob_in, ctx_ff, ctx_in, k_ff, k_in, j_ff, j_in;
   logic [23:0] s_ff, s_in, s_new;
   logic        rv_ff, rv_in;
   logic [7:0]  rdata_ff, rdata_in;
   logic [3:0]  ruser_ff, ruser_in;

   // Memories
   logic [15:0] freq_mem [65536];
   logic [15:0] tot_mem  [256];
   logic [7:0]  win_mem  [65536];
   logic [15:0] freq_rd, tot_rd;
   logic [7:0]  win_rd;
   logic [15:0] freq_raddr, freq_waddr, freq_wdata, win_raddr, win_waddr;
   logic [7:0]  win_wdata, tot_waddr;
   logic [15:0] tot_wdata;
   logic        freq_we, win_we, tot_we;

   // Shared divider
   logic        div_start, div_done;
   logic [31:0] div_num, div_den, div_q;

   logic [31:0] hi_sum, sl_low, sl_range;
   logic        needs;
   logic [15:0] off, rs_v;
   logic [1:0]  status;

   lzrc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   // Read addresses
   assign freq_raddr = (state_ff == S_RSA || state_ff == S_RSB) ? {ctx_ff, j_ff} : {ctx_ff, k_ff};
   assign win_raddr  = (phase_ff == PH_IDLE) ? copy_ff : wp_ff - 16'd1;

   always_ff @(posedge clock) begin
      freq_rd <= freq_mem[freq_raddr];
      win_rd  <= win_mem[win_raddr];
      tot_rd  <= tot_mem[ctx_ff];
      if (freq_we) freq_mem[freq_waddr] <= freq_wdata;
      if (win_we)  win_mem[win_waddr]   <= win_wdata;
      if (tot_we)  tot_mem[tot_waddr]   <= tot_wdata;
   end

   // Normalisation test, byte shift-in and helper values (walk sum, offset, rescale, status)
   assign hi_sum   = low_ff + range_ff;
   assign needs    = (code_ff < low_ff) || ((low_ff ^ hi_sum) < 32'h0100_0000)
                     || (range_ff < 32'h0001_0000);
   assign sl_low   = {low_ff[23:0], 8'h00};
   assign sl_range = {range_ff[23:0], 8'h00};
   assign s_new    = s_ff + {8'h00, freq_rd};
   assign off      = {k_ff, offlo_ff};
   assign rs_v     = {1'b0, freq_rd[15:1]} | {15'd0, freq_rd[0]};
   assign status   = (phase_ff == PH_END) ? ST_END : ((phase_ff >= PH_BAD) ? ST_BAD : ST_RUN);

   // Sequencer
   always_comb begin
      state_in = state_ff; phase_in = phase_ff; low_in = low_ff; code_in = code_ff;
      range_in = range_ff; idx_in = idx_ff; copy_in = copy_ff; wp_in = wp_ff;
      tot_in = tot_ff; f_in = f_ff; clr_in = clr_ff; run_in = run_ff; fill_in = fill_ff;
      avail_in = avail_ff; taken_in = taken_ff; emit_in = emit_ff; mask_in = mask_ff;
      flag_in = flag_ff; mlen_in = mlen_ff; offlo_in = offlo_ff; byte_in = byte_ff;
      ob_in = ob_ff; ctx_in = ctx_ff; k_in = k_ff; j_in = j_ff; s_in = s_ff;
      rv_in = rv_ff; rdata_in = rdata_ff; ruser_in = ruser_ff;
      freq_we = 1'b0; freq_waddr = {ctx_ff, k_ff}; freq_wdata = f_ff + 16'd1;
      win_we = 1'b0; win_waddr = wp_ff; win_wdata = win_rd;
      tot_we = 1'b0; tot_waddr = ctx_ff; tot_wdata = tot_ff;
      div_start = 1'b0; div_num = range_ff; div_den = {16'd0, tot_rd};

      // Drop a delivered result
      if (rv_ff && rsp_tready) rv_in = 1'b0;

      unique case (state_ff)
         S_CLEAR: begin
            freq_we = 1'b1; freq_waddr = clr_ff; freq_wdata = 16'd1;
            win_we = 1'b1; win_waddr = clr_ff; win_wdata = 8'hFF;
            tot_we = 1'b1; tot_waddr = clr_ff[7:0]; tot_wdata = 16'd256;
            clr_in = clr_ff + 16'd1;
            if (clr_ff == 16'hFFFF) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               avail_in = req_tuser; byte_in = req_tdata;
               taken_in = 1'b0; emit_in = 1'b0; ob_in = 8'h00;
               state_in = S_STEP;
            end
         end
         S_STEP: begin
            if (phase_ff == PH_END || phase_ff == PH_BAD) begin
               state_in = S_DONE;
            end else if (phase_ff > PH_BAD) begin
               phase_in = PH_BAD; state_in = S_DONE;
            end else if (phase_ff < PH_IDLE) begin
               if (!avail_ff || taken_ff) state_in = S_DONE;
               else begin
                  code_in = {code_ff[23:0], byte_ff}; taken_in = 1'b1;
                  phase_in = phase_ff + 4'd1;
               end
            end else if (phase_ff == PH_IDLE) begin
               if (run_ff != 9'd0) begin
                  if (fill_ff) begin
                     ob_in = copy_ff[7:0];
                     win_we = 1'b1; win_wdata = copy_ff[7:0];
                     wp_in = wp_ff + 16'd1; run_in = run_ff - 9'd1; emit_in = 1'b1;
                     state_in = S_DONE;
                  end else state_in = S_WINWR;
               end else if (mask_ff != 8'h00) phase_in = flag_ff[7] ? PH_LIT : PH_MLEN;
               else phase_in = PH_FLAG;
            end else if (needs) begin
               if (!avail_ff || taken_ff) state_in = S_DONE;
               else begin
                  code_in = {code_ff[23:0], byte_ff};
                  low_in = sl_low;
                  range_in = (sl_range + sl_low < sl_low) ? ~sl_low : sl_range;
                  taken_in = 1'b1;
               end
            end else if (phase_ff == PH_LIT) begin
               state_in = S_CTX;
            end else begin
               ctx_in = (phase_ff == PH_FLAG) ? 8'd0 : {4'd0, phase_ff - PH_MLEN + 4'd1};
               state_in = S_TOTRD;
            end
         end
         S_WINWR: begin
            ob_in = win_rd; win_we = 1'b1;
            wp_in = wp_ff + 16'd1; copy_in = copy_ff + 16'd1;
            run_in = run_ff - 9'd1; emit_in = 1'b1; state_in = S_DONE;
         end
         S_CTX: begin
            ctx_in = win_rd; state_in = S_TOTRD;
         end
         S_TOTRD: state_in = S_DIVR;
         S_DIVR: begin
            tot_in = tot_rd;
            if (tot_rd == 16'd0) begin
               phase_in = PH_BAD; state_in = S_DONE;
            end else begin
               div_start = 1'b1; state_in = S_DIVRW;
            end
         end
         S_DIVRW: begin
            div_num = code_ff - low_ff; div_den = div_q;
            if (div_done) begin
               range_in = div_q;
               if (div_q == 32'd0) begin
                  phase_in = PH_BAD; state_in = S_DONE;
               end else begin
                  div_start = 1'b1; state_in = S_DIVIW;
               end
            end
         end
         S_DIVIW: begin
            if (div_done) begin
               idx_in = div_q;
               if (div_q >= {16'd0, tot_ff}) begin
                  phase_in = PH_BAD; state_in = S_DONE;
               end else begin
                  k_in = 8'd0; s_in = '0; state_in = S_WALKA;
               end
            end
         end
         S_WALKA: state_in = S_WALKB;
         S_WALKB: begin
            s_in = s_new;
            if ({8'd0, s_new} > idx_ff) begin
               f_in = freq_rd; state_in = S_MUL1;
            end else if (k_ff == 8'hFF) begin
               phase_in = PH_BAD; state_in = S_DONE;
            end else begin
               k_in = k_ff + 8'd1; state_in = S_WALKA;
            end
         end
         S_MUL1: begin
            low_in = low_ff + 32'(range_ff * (s_ff - {8'd0, f_ff}));
            state_in = S_MUL2;
         end
         S_MUL2: begin
            range_in = 32'(range_ff * f_ff);
            freq_we = 1'b1;
            tot_in = tot_ff + 16'd1;
            if (tot_ff == 16'hFFFF) begin
               j_in = 8'd0; state_in = S_RSA;
            end else state_in = S_SYM;
         end
         S_RSA: state_in = S_RSB;
         S_RSB: begin
            freq_we = 1'b1; freq_waddr = {ctx_ff, j_ff}; freq_wdata = rs_v;
            tot_in = tot_ff + rs_v;
            j_in = j_ff + 8'd1;
            state_in = (j_ff == 8'hFF) ? S_SYM : S_RSA;
         end
         S_SYM: begin
            tot_we = 1'b1;
            state_in = S_STEP;
            case (phase_ff)
               PH_FLAG: begin
                  flag_in = k_ff; mask_in = 8'hFF; phase_in = PH_IDLE;
               end
               PH_LIT: begin
                  copy_in = {8'd0, k_ff}; fill_in = 1'b1; run_in = 9'd1;
                  flag_in = {flag_ff[6:0], 1'b0}; mask_in = {mask_ff[6:0], 1'b0};
                  phase_in = PH_IDLE;
               end
               PH_MLEN: begin
                  mlen_in = k_ff; phase_in = PH_OFFLO;
               end
               PH_OFFLO: begin
                  offlo_in = k_ff; phase_in = PH_OFFHI;
               end
               default: begin
                  run_in = 9'd4 + {1'b0, mlen_ff};
                  if (off == 16'd256) begin
                     phase_in = PH_END; state_in = S_DONE;
                  end else begin
                     if (off > 16'd256) begin
                        copy_in = ~off + wp_ff + 16'd259; fill_in = 1'b0;
                     end else begin
                        copy_in = off; fill_in = 1'b1;
                     end
                     flag_in = {flag_ff[6:0], 1'b0}; mask_in = {mask_ff[6:0], 1'b0};
                     phase_in = PH_IDLE;
                  end
               end
            endcase
         end
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rv_in = 1'b1;
               rdata_in = emit_ff ? ob_ff : 8'h00;
               ruser_in = {status, emit_ff, taken_ff};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; phase_ff <= 4'd0; low_ff <= '0; code_ff <= '0;
         range_ff <= 32'hFFFF_FFFF; copy_ff <= 16'hFFFF; run_ff <= '0; fill_ff <= 1'b0;
         mask_ff <= '0; flag_ff <= '0; mlen_ff <= '0; offlo_ff <= '0; wp_ff <= '0;
         clr_ff <= '0; rv_ff <= 1'b0; taken_ff <= 1'b0; emit_ff <= 1'b0; avail_ff <= 1'b0;
      end else begin
         state_ff <= state_in; phase_ff <= phase_in; low_ff <= low_in; code_ff <= code_in;
         range_ff <= range_in; copy_ff <= copy_in; run_ff <= run_in; fill_ff <= fill_in;
         mask_ff <= mask_in; flag_ff <= flag_in; mlen_ff <= mlen_in; offlo_ff <= offlo_in;
         wp_ff <= wp_in; clr_ff <= clr_in; rv_ff <= rv_in; taken_ff <= taken_in;
         emit_ff <= emit_in; avail_ff <= avail_in;
      end
      idx_ff <= idx_in; tot_ff <= tot_in; f_ff <= f_in; byte_ff <= byte_in; ob_ff <= ob_in;
      ctx_ff <= ctx_in; k_ff <= k_in; j_ff <= j_in; s_ff <= s_in;
      rdata_ff <= rdata_in; ruser_ff <= ruser_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = rdata_ff;
   assign rsp_tuser  = ruser_ff;

   `LZRC_ASSERT_IMP(a_take_needs_offer, clock, reset,
      taken_ff && state_ff != S_IDLE, avail_ff, "byte taken without an offer")
   `LZRC_ASSERT_IMP(a_emit_in_idle_phase, clock, reset,
      state_ff == S_DONE && emit_ff, phase_ff == PH_IDLE, "byte emitted outside run phase")
   `LZRC_ASSERT_NXT(a_clear_then_idle, clock, reset,
      state_ff == S_CLEAR && clr_ff == 16'hFFFF, state_ff == S_IDLE, "clearing pass did not finish")
endmodule
`default_nettype wire

// File: sv/lzrc_div.sv
// Restoring 32-bit divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
`include "lz_range_coder_decompressor_defines.svh"
module lzrc_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [31:0] dividend,
   input  wire logic [31:0] divisor,
   output logic             done,
   output logic [31:0]      quotient
);
   import lzrc_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   // Shift in one dividend bit and try a subtract
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(WordW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   `LZRC_ASSERT_IMP(a_div_nonzero, clock, reset, start, divisor != 32'd0, "divide by zero started")
   `LZRC_ASSERT_IMP(a_div_no_restart, clock, reset, busy_ff, !start, "divider restarted while busy")
endmodule
`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for the range-coded LZ77 stream decompressor.
`timescale 1ns / 1ps
`default_nettype none

// Stream of decoded-byte responses: hold what each accepted transfer in should give.
typedef struct packed {
   logic [7:0] out_byte;
   logic [3:0] flags;   // byte_taken, out_valid, status[1:0]
} lz_rsp_type;

class lz_rsp_scoreboard;
   lz_rsp_type pending_q[$];
   int         errors = 0;

   task report_mismatch(string msg);
      $display("mismatch: %s", msg);
      errors++;
   endtask

   // Queue the response predicted for one accepted transfer in.
   function void note_request(lz_rsp_type want);
      pending_q.push_back(want);
   endfunction

   // Compare one transfer out against the oldest prediction.
   task check_response(logic [7:0] data, logic [3:0] user);
      lz_rsp_type want;
      if (pending_q.size() == 0) begin
         report_mismatch($sformatf("unexpected response data=%h user=%h", data, user));
      end else begin
         want = pending_q.pop_front();
         if (user[0] !== want.flags[0])
            report_mismatch($sformatf("byte_taken %b want %b", user[0], want.flags[0]));
         if (user[1] !== want.flags[1])
            report_mismatch($sformatf("out_valid %b want %b", user[1], want.flags[1]));
         if (user[3:2] !== want.flags[3:2])
            report_mismatch($sformatf("status %0d want %0d", user[3:2], want.flags[3:2]));
         if (data !== want.out_byte)
            report_mismatch($sformatf("out_byte %h want %h", data, want.out_byte));
      end
   endtask
endclass

module tb_top;
   import lzrc_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic       req_tuser = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;
   logic [3:0] rsp_tuser;

   lz_range_coder_decompressor u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lz_rsp_scoreboard sb = new();

   // Decoder mirror: tables, window and coder registers
   logic [15:0] dec_freq [65536];
   logic [15:0] dec_tot  [256];
   logic [7:0]  dec_win  [65536];
   logic [31:0] d_low, d_code, d_range;
   logic [15:0] d_src, d_wp;
   logic [8:0]  d_run;
   logic        d_fill;
   logic [7:0]  d_mask, d_flag;
   logic [23:0] d_match;
   logic [3:0]  d_phase;

   // Encoder side used to build well-formed compressed streams
   logic [15:0] enc_freq [65536];
   logic [15:0] enc_tot  [256];
   logic [7:0]  enc_win  [65536];
   logic [15:0] enc_wp;
   logic [31:0] e_low, e_range;
   logic [7:0]  comp_q[$];

   function automatic void clear_models();
      for (int i = 0; i < 65536; i++) begin
         dec_freq[i] = 16'd1;
         enc_freq[i] = 16'd1;
         dec_win[i]  = 8'hFF;
         enc_win[i]  = 8'hFF;
      end
      for (int i = 0; i < 256; i++) begin
         dec_tot[i] = 16'd256;
         enc_tot[i] = 16'd256;
      end
      d_low = '0; d_code = '0; d_range = 32'hFFFF_FFFF;
      d_src = 16'hFFFF; d_run = '0; d_fill = 1'b0; d_mask = '0; d_flag = '0;
      d_match = '0; d_wp = '0; d_phase = 4'd0;
      enc_wp = '0; e_low = '0; e_range = 32'hFFFF_FFFF;
   endfunction

   // Decode one symbol in a context; 0 means a zero total or range, or an out-of-range code.
   function automatic bit decode_symbol(logic [7:0] ctx, output logic [7:0] sym);
      int unsigned base, tot, r, idx, s, k, f, v;
      base = ctx * 256;
      tot = 32'(dec_tot[ctx]);
      sym = 8'h00;
      if (tot == 0) return 1'b0;
      r = d_range / tot;
      d_range = r;
      if (r == 0) return 1'b0;
      idx = (d_code - d_low) / r;
      if (idx >= tot) return 1'b0;
      s = 0;
      k = 0;
      while (k < 256) begin
         s += 32'(dec_freq[base + k]);
         if (s > idx) break;
         k++;
      end
      if (k >= 256) return 1'b0;
      f = 32'(dec_freq[base + k]);
      d_low += (s - f) * r;
      d_range = r * f;
      dec_freq[base + k] = 16'(f + 1);
      tot = (tot + 1) & 32'hFFFF;
      if (tot == 0) begin
         for (int j = 0; j < 256; j++) begin
            v = 32'(dec_freq[base + j]);
            v = (v >> 1) | (v & 1);
            dec_freq[base + j] = 16'(v);
            tot += v;
         end
         tot &= 32'hFFFF;
      end
      dec_tot[ctx] = 16'(tot);
      sym = 8'(k);
      return 1'b1;
   endfunction

   // Advance the decoder mirror by one offered item and give the response.
   function automatic lz_rsp_type predict_response(logic avail, logic [7:0] b);
      logic        taken, emitted;
      logic [7:0]  ob, sym, ctx;
      logic [3:0]  ph;
      logic [31:0] hi;
      logic [15:0] off, noff;
      logic [1:0]  st;
      lz_rsp_type  res;
      taken = 1'b0; emitted = 1'b0; ob = '0; sym = '0;
      while (1) begin
         ph = d_phase;
         if (ph == PH_END || ph == PH_BAD) break;
         if (ph > PH_BAD) begin
            d_phase = PH_BAD;
            break;
         end
         // priming: fill the code value
         if (ph < PH_IDLE) begin
            if (!avail || taken) break;
            d_code = {d_code[23:0], b};
            taken = 1'b1;
            d_phase = 4'(ph + 1);
            continue;
         end
         if (ph == PH_IDLE) begin
            if (d_run != 0) begin
               if (d_fill) begin
                  ob = d_src[7:0];
               end else begin
                  ob = dec_win[d_src];
                  d_src = d_src + 16'd1;
               end
               dec_win[d_wp] = ob;
               d_wp = d_wp + 16'd1;
               d_run = d_run - 9'd1;
               emitted = 1'b1;
               break;
            end
            if (d_mask != 0) d_phase = d_flag[7] ? PH_LIT : PH_MLEN;
            else d_phase = PH_FLAG;
            continue;
         end
         // normalise one byte at a time
         hi = d_low + d_range;
         if (d_code < d_low || (d_low ^ hi) < 32'h0100_0000 || d_range < 32'h0001_0000) begin
            if (!avail || taken) break;
            d_code = {d_code[23:0], b};
            d_low = d_low << 8;
            d_range = d_range << 8;
            if (32'(d_range + d_low) < d_low) d_range = ~d_low;
            taken = 1'b1;
            continue;
         end
         if (ph == PH_FLAG) ctx = 8'd0;
         else if (ph == PH_LIT) ctx = dec_win[16'(d_wp - 16'd1)];
         else ctx = 8'(ph - PH_MLEN + 4'd1);
         if (!decode_symbol(ctx, sym)) begin
            d_phase = PH_BAD;
            break;
         end
         if (ph == PH_FLAG) begin
            d_flag = sym;
            d_mask = 8'hFF;
            d_phase = PH_IDLE;
         end else if (ph == PH_LIT) begin
            d_src = {8'h00, sym};
            d_fill = 1'b1;
            d_run = 9'd1;
            d_flag = d_flag << 1; d_mask = d_mask << 1; d_phase = PH_IDLE;
         end else if (ph == PH_MLEN) begin
            d_match[7:0] = sym;
            d_phase = PH_OFFLO;
         end else if (ph == PH_OFFLO) begin
            d_match[15:8] = sym;
            d_phase = PH_OFFHI;
         end else begin
            d_match[23:16] = sym;
            off = d_match[23:8];
            d_run = 9'd4 + {1'b0, d_match[7:0]};
            if (off == 16'd256) begin
               d_phase = PH_END;
               break;
            end
            if (off > 16'd256) begin
               noff = ~off;
               d_src = noff + d_wp + 16'd259;
               d_fill = 1'b0;
            end else begin
               d_src = off;
               d_fill = 1'b1;
            end
            d_flag = d_flag << 1; d_mask = d_mask << 1; d_phase = PH_IDLE;
         end
      end
      st = (d_phase == PH_END) ? ST_END : ((d_phase >= PH_BAD) ? ST_BAD : ST_RUN);
      res.out_byte = emitted ? ob : 8'h00;
      res.flags = {st, emitted, taken};
      return res;
   endfunction

   // Range-encode one symbol and push out any settled top bytes.
   function automatic void encode_symbol(logic [7:0] ctx, logic [7:0] sym);
      int unsigned base, tot, r, cum, f, v;
      logic [31:0] hi;
      base = ctx * 256;
      tot = 32'(enc_tot[ctx]);
      cum = 0;
      for (int j = 0; j < int'(sym); j++) cum += 32'(enc_freq[base + j]);
      f = 32'(enc_freq[base + sym]);
      r = e_range / tot;
      e_low += cum * r;
      e_range = r * f;
      enc_freq[base + sym] = 16'(f + 1);
      tot = (tot + 1) & 32'hFFFF;
      if (tot == 0) begin
         for (int j = 0; j < 256; j++) begin
            v = 32'(enc_freq[base + j]);
            v = (v >> 1) | (v & 1);
            enc_freq[base + j] = 16'(v);
            tot += v;
         end
         tot &= 32'hFFFF;
      end
      enc_tot[ctx] = 16'(tot);
      hi = e_low + e_range;
      while ((e_low ^ hi) < 32'h0100_0000 || e_range < 32'h0001_0000) begin
         comp_q.push_back(e_low[31:24]);
         e_low = e_low << 8;
         e_range = e_range << 8;
         if (32'(e_range + e_low) < e_low) e_range = ~e_low;
         hi = e_low + e_range;
      end
   endfunction

   function automatic void encode_literal(logic [7:0] b);
      encode_symbol(enc_win[16'(enc_wp - 16'd1)], b);
      enc_win[enc_wp] = b;
      enc_wp = enc_wp + 16'd1;
   endfunction

   // Encode a match, fill or end token and replay a match or fill into the window.
   function automatic void encode_match(logic [7:0] len, logic [15:0] off);
      logic [15:0] src, noff;
      logic [7:0]  ob;
      encode_symbol(8'd1, len);
      encode_symbol(8'd2, off[7:0]);
      encode_symbol(8'd3, off[15:8]);
      if (off == 16'd256) return;
      noff = ~off;
      src = noff + enc_wp + 16'd259;
      for (int i = 0; i < 4 + int'(len); i++) begin
         if (off < 16'd256) begin
            ob = off[7:0];
         end else begin
            ob = enc_win[src];
            src = src + 16'd1;
         end
         enc_win[enc_wp] = ob;
         enc_wp = enc_wp + 16'd1;
      end
   endfunction

   function automatic void encode_flush();
      for (int i = 0; i < 4; i++) begin
         comp_q.push_back(e_low[31:24]);
         e_low = e_low << 8;
      end
   endfunction

   // Build the whole compressed stream: one directed group, then random groups.
   function automatic void build_stream(bit with_end);
      logic [7:0]  flag;
      logic [15:0] off;
      // directed group: literals 00/FF/80, fills 0 and 255, copies 257, FFFF and 300
      encode_symbol(8'd0, 8'hC2);
      encode_literal(8'h00);
      encode_literal(8'hFF);
      encode_match(8'd0, 16'd0);
      encode_match(8'd255, 16'd255);
      encode_match(8'd3, 16'd257);
      encode_match(8'd1, 16'hFFFF);
      encode_literal(8'h80);
      encode_match(8'd2, 16'd300);
      for (int g = 0; g < 6; g++) begin
         flag = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 3) != 0) flag = flag | 8'h6D;
         encode_symbol(8'd0, flag);
         for (int t = 0; t < 8; t++) begin
            if (with_end && g == 5 && t == 7) begin
               if (flag[7]) encode_literal(8'($urandom_range(0, 255)));
               else encode_match(8'($urandom_range(0, 255)), 16'd256);
            end else if (flag[7]) begin
               if ($urandom_range(0, 1) != 0) encode_literal(8'($urandom_range(97, 102)));
               else encode_literal(8'($urandom_range(0, 255)));
            end else begin
               if ($urandom_range(0, 4) < 2) off = 16'($urandom_range(0, 255));
               else if ($urandom_range(0, 3) != 0) off = 16'(257 + $urandom_range(0, 40));
               else off = 16'($urandom_range(257, 65535));
               encode_match(8'($urandom_range(0, 7)), off);
            end
            flag = flag << 1;
         end
      end
      encode_flush();
      // no end token: trail with noise until the decoder loses the thread
      if (!with_end)
         for (int i = 0; i < 40; i++) comp_q.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Sender side: one transfer in, with a random pre-gap
   int send_burst = 0;

   task automatic send_item(input logic avail, input logic [7:0] b, output logic taken);
      int         gap;
      lz_rsp_type want;
      if (send_burst > 0) begin
         gap = 0;
         send_burst--;
      end else if ($urandom_range(0, 15) == 0) begin
         gap = 0;
         send_burst = $urandom_range(5, 30);
      end else begin
         gap = $urandom_range(0, 7);
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= avail;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      want = predict_response(avail, b);
      taken = want.flags[0];
      sb.note_request(want);
      @(negedge clock);
   endtask

   // Receiver side: random stall before each transfer out
   initial begin
      int stall;
      int rcv_burst;
      rcv_burst = 0;
      @(negedge clock);
      forever begin
         if (rcv_burst > 0) begin
            stall = 0;
            rcv_burst--;
         end else if ($urandom_range(0, 15) == 0) begin
            stall = 0;
            rcv_burst = $urandom_range(5, 30);
         end else begin
            stall = $urandom_range(0, 7);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   // Main stimulus
   initial begin
      logic taken;
      logic avail;
      logic [7:0] b;
      int guard;
      int sent;
      clear_models();
      build_stream(1'($urandom_range(0, 1)));
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // nothing offered while priming, with both extremes on the ignored data
      send_item(1'b0, 8'h00, taken);
      send_item(1'b0, 8'hFF, taken);
      sent = 0;
      guard = 0;
      while (comp_q.size() > 0 && d_phase < PH_END && guard < 1500) begin
         avail = ($urandom_range(0, 4) != 0);
         b = avail ? comp_q[0] : 8'($urandom_range(0, 255));
         send_item(avail, b, taken);
         if (taken) void'(comp_q.pop_front());
         sent++;
         guard++;
         // drain once mid-stream
         if (sent == 40) begin
            req_tvalid <= 1'b0;
            while (sb.pending_q.size() != 0) @(negedge clock);
         end
      end
      // halted or exhausted: every further item should be refused or idle
      for (int i = 0; i < 20; i++) begin
         send_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), taken);
      end
      req_tvalid <= 1'b0;
      while (sb.pending_q.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (sb.errors == 0 && sb.pending_q.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #500ms;
      $display("tb: failure");
      $finish;
   end
endmodule

`default_nettype wire

// File: files.f
+incdir+sv
sv/lzrc_pkg.sv
sv/lzrc_div.sv
sv/lz_range_coder_decompressor.sv
tb/tb_top.sv
